// ===== design/qets_pkg.sv =====
// ----------------------------------------------------------------------------
// qets_pkg: shared types and constants of the quad-edge topology store
// Arc encoding, operation codes, sequencer states and the memory request
// that travels from the sequencer to the link memory.
// ----------------------------------------------------------------------------
package qets_pkg;

    // Number of edge records. The record index is reduced by keeping its low
    // bits, so this count is a power of two.
    localparam int EDGE_COUNT = 1024;
    // Largest walk length; longer walks saturate to this many steps.
    localparam int STEP_LIMIT = 1023;

    localparam int MODE_W    = 2;
    localparam int IN_EDGE_W = 10;
    localparam int CODE_W    = 2;
    localparam int ROT_W     = 2;
    localparam int STEP_W    = 11;

    localparam int EDGE_W    = $clog2(EDGE_COUNT);
    localparam int ARC_W     = EDGE_W + CODE_W;
    localparam int SLOT_COUNT = 4 * EDGE_COUNT;

    // A step field of STEP_W bits has a magnitude of at most 2^(STEP_W-1).
    localparam int STEP_MAG_MAX = 1 << (STEP_W - 1);
    localparam int STEP_CAP  = (STEP_LIMIT < STEP_MAG_MAX) ? STEP_LIMIT : STEP_MAG_MAX;
    localparam int CNT_W     = $clog2(STEP_CAP + 1);
    localparam int MAG_W     = STEP_W + 1;

    typedef logic [ARC_W-1:0]  arc_t;
    typedef logic [CODE_W-1:0] code_t;

    // Tumble codes: the arc is the base arc rotated this many times.
    localparam code_t TURN_0 = 2'd0;
    localparam code_t TURN_1 = 2'd1;
    localparam code_t TURN_2 = 2'd2;
    localparam code_t TURN_3 = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_MAKE    = 2'd0,
        MODE_SPLICE  = 2'd1,
        MODE_DESTROY = 2'd2,
        MODE_WALK    = 2'd3
    } qets_mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MK0,
        S_MK1,
        S_MK2,
        S_MK3,
        S_SP_RA,
        S_SP_RB,
        S_SP_RU,
        S_SP_RV,
        S_SP_WA,
        S_SP_WB,
        S_SP_WU,
        S_SP_WV,
        S_DS_RD,
        S_DS_CHK,
        S_DS_OP,
        S_DS_NEXT,
        S_WK_INIT,
        S_WK_RD,
        S_WK_CAP,
        S_WK_END,
        S_FIN
    } qets_state_t;

    typedef struct packed {
        logic we;
        logic re;
        arc_t addr;
        arc_t wdata;
    } qets_mem_req_t;

    // Builds an arc from a host edge index and a tumble code.
    function automatic arc_t arc_of(input logic [IN_EDGE_W-1:0] edge_idx, input code_t code);
        logic [IN_EDGE_W+EDGE_W-1:0] wide;
        wide = {{EDGE_W{1'b0}}, edge_idx};
        return {wide[EDGE_W-1:0], code};
    endfunction

    // Edge index of an arc at the width of the result field.
    function automatic logic [IN_EDGE_W-1:0] edge_of(input arc_t x);
        logic [IN_EDGE_W+EDGE_W-1:0] wide;
        wide = {{IN_EDGE_W{1'b0}}, x[ARC_W-1:CODE_W]};
        return wide[IN_EDGE_W-1:0];
    endfunction

    // Same edge record, different tumble code.
    function automatic arc_t with_code(input arc_t x, input code_t code);
        return {x[ARC_W-1:CODE_W], code};
    endfunction

endpackage

// ===== design/qets_cmd_if.sv =====
// ----------------------------------------------------------------------------
// qets_cmd_if: operation channel of the quad-edge topology store
// Valid/ready channel that carries one operation item.
// ----------------------------------------------------------------------------
interface qets_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic        [qets_pkg::MODE_W-1:0]    mode;
    logic        [qets_pkg::IN_EDGE_W-1:0] arc_a_edge;
    logic        [qets_pkg::CODE_W-1:0]    arc_a_code;
    logic        [qets_pkg::IN_EDGE_W-1:0] arc_b_edge;
    logic        [qets_pkg::CODE_W-1:0]    arc_b_code;
    logic        [qets_pkg::ROT_W-1:0]     rot_count;
    logic signed [qets_pkg::STEP_W-1:0]    step_count;

    modport source (
        output valid, mode, arc_a_edge, arc_a_code, arc_b_edge, arc_b_code,
               rot_count, step_count,
        input  ready
    );

    modport sink (
        input  valid, mode, arc_a_edge, arc_a_code, arc_b_edge, arc_b_code,
               rot_count, step_count,
        output ready
    );
endinterface

// ===== design/qets_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qets_rsp_if: result channel of the quad-edge topology store
// Valid/ready channel that carries one resulting arc item.
// ----------------------------------------------------------------------------
interface qets_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [qets_pkg::IN_EDGE_W-1:0]   result_edge;
    logic [qets_pkg::CODE_W-1:0]      result_code;

    modport source (
        output valid, result_edge, result_code,
        input  ready
    );

    modport sink (
        input  valid, result_edge, result_code,
        output ready
    );
endinterface

// ===== design/qets_ram.sv =====
// ----------------------------------------------------------------------------
// qets_ram: generic single-port RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module qets_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/qets_arc_unit.sv =====
// ----------------------------------------------------------------------------
// qets_arc_unit: shared arc arithmetic
// Turns an arc by a rotation count and compares two arcs.
// ----------------------------------------------------------------------------
module qets_arc_unit (
    input  qets_pkg::arc_t  turn_arc,
    input  qets_pkg::code_t turn_k,
    output qets_pkg::arc_t  turned,
    input  qets_pkg::arc_t  cmp_x,
    input  qets_pkg::arc_t  cmp_y,
    output logic            same
);

    qets_pkg::code_t code_sum;

    // The code wraps modulo four; the edge part is untouched.
    assign code_sum = turn_arc[qets_pkg::CODE_W-1:0] + turn_k;
    assign turned   = qets_pkg::with_code(turn_arc, code_sum);
    assign same     = (cmp_x == cmp_y);

endmodule

// ===== design/qets_seq.sv =====
// ----------------------------------------------------------------------------
// qets_seq: operation sequencer of the quad-edge topology store
// Steps through the link reads and writes of one operation, drives the
// link memory and holds the result item in an output register.
// ----------------------------------------------------------------------------
module qets_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    qets_cmd_if.sink                cmd,
    qets_rsp_if.source              rsp,
    output qets_pkg::qets_mem_req_t mem_req,
    input  qets_pkg::arc_t          rdata
);

    qets_pkg::qets_state_t state_reg, state_next;
    qets_pkg::qets_mode_t  mode_reg, mode_next;
    logic                  phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [qets_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    qets_pkg::code_t       rot_reg, rot_next;
    qets_pkg::arc_t        a_reg, a_next;
    qets_pkg::arc_t        b_reg, b_next;
    qets_pkg::arc_t        u_reg, u_next;
    qets_pkg::arc_t        v_reg, v_next;
    qets_pkg::arc_t        ta_reg, ta_next;
    qets_pkg::arc_t        tb_reg, tb_next;
    qets_pkg::arc_t        tu_reg, tu_next;
    qets_pkg::arc_t        tv_reg, tv_next;
    qets_pkg::arc_t        res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    qets_pkg::arc_t        out_arc_reg, out_arc_next;

    qets_pkg::arc_t        turn_arc;
    qets_pkg::code_t       turn_k;
    qets_pkg::arc_t        turned;
    logic                  same;
    logic                  accept;
    logic                  out_free;
    qets_pkg::arc_t        in_a;
    qets_pkg::arc_t        in_b;
    logic signed [qets_pkg::MAG_W-1:0] step_ext;
    logic [qets_pkg::MAG_W-1:0]        step_mag;

    qets_arc_unit u_arc (
        .turn_arc (turn_arc),
        .turn_k   (turn_k),
        .turned   (turned),
        .cmp_x    (rdata),
        .cmp_y    (a_reg),
        .same     (same)
    );

    assign cmd.ready   = (state_reg == qets_pkg::S_IDLE);
    assign accept      = cmd.valid && cmd.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.result_edge = qets_pkg::edge_of(out_arc_reg);
    assign rsp.result_code = out_arc_reg[qets_pkg::CODE_W-1:0];

    assign in_a     = qets_pkg::arc_of(cmd.arc_a_edge, cmd.arc_a_code);
    assign in_b     = qets_pkg::arc_of(cmd.arc_b_edge, cmd.arc_b_code);
    assign step_ext = qets_pkg::MAG_W'(cmd.step_count);
    assign step_mag = step_ext[qets_pkg::MAG_W-1] ? qets_pkg::MAG_W'(-step_ext)
                                                  : qets_pkg::MAG_W'(step_ext);

    // Operand selection for the shared arc unit.
    always_comb
    begin
        turn_arc = a_reg;
        turn_k   = qets_pkg::TURN_0;
        unique case (state_reg)
            qets_pkg::S_DS_CHK:
            begin
                turn_k = qets_pkg::TURN_1;
            end
            qets_pkg::S_DS_OP:
            begin
                turn_arc = rdata;
                turn_k   = qets_pkg::TURN_1;
            end
            qets_pkg::S_DS_NEXT:
            begin
                turn_k = qets_pkg::TURN_2;
            end
            qets_pkg::S_SP_RU:
            begin
                turn_arc = ta_reg;
                turn_k   = qets_pkg::TURN_1;
            end
            qets_pkg::S_SP_RV:
            begin
                turn_arc = tb_reg;
                turn_k   = qets_pkg::TURN_1;
            end
            qets_pkg::S_WK_INIT:
            begin
                turn_k = rot_reg;
            end
            qets_pkg::S_WK_RD:
            begin
                turn_k = neg_reg ? qets_pkg::TURN_1 : qets_pkg::TURN_0;
            end
            qets_pkg::S_WK_CAP:
            begin
                turn_arc = rdata;
                turn_k   = neg_reg ? qets_pkg::TURN_1 : qets_pkg::TURN_0;
            end
            qets_pkg::S_WK_END:
            begin
                turn_k = qets_pkg::TURN_0 - rot_reg;
            end
            default:
            begin
                turn_k = qets_pkg::TURN_0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qets_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (qets_pkg::qets_mode_t'(cmd.mode))
                        qets_pkg::MODE_MAKE:    state_next = qets_pkg::S_MK0;
                        qets_pkg::MODE_SPLICE:  state_next = qets_pkg::S_SP_RA;
                        qets_pkg::MODE_DESTROY: state_next = qets_pkg::S_DS_RD;
                        qets_pkg::MODE_WALK:    state_next = qets_pkg::S_WK_INIT;
                        default:                state_next = qets_pkg::S_IDLE;
                    endcase
                end
            end
            qets_pkg::S_MK0:   state_next = qets_pkg::S_MK1;
            qets_pkg::S_MK1:   state_next = qets_pkg::S_MK2;
            qets_pkg::S_MK2:   state_next = qets_pkg::S_MK3;
            qets_pkg::S_MK3:   state_next = qets_pkg::S_FIN;
            qets_pkg::S_SP_RA: state_next = qets_pkg::S_SP_RB;
            qets_pkg::S_SP_RB: state_next = qets_pkg::S_SP_RU;
            qets_pkg::S_SP_RU: state_next = qets_pkg::S_SP_RV;
            qets_pkg::S_SP_RV: state_next = qets_pkg::S_SP_WA;
            qets_pkg::S_SP_WA: state_next = qets_pkg::S_SP_WB;
            qets_pkg::S_SP_WB: state_next = qets_pkg::S_SP_WU;
            qets_pkg::S_SP_WU: state_next = qets_pkg::S_SP_WV;
            qets_pkg::S_SP_WV:
            begin
                if (mode_reg == qets_pkg::MODE_DESTROY && !phase_reg)
                begin
                    state_next = qets_pkg::S_DS_NEXT;
                end
                else
                begin
                    state_next = qets_pkg::S_FIN;
                end
            end
            qets_pkg::S_DS_RD: state_next = qets_pkg::S_DS_CHK;
            qets_pkg::S_DS_CHK:
            begin
                if (!same)
                begin
                    state_next = qets_pkg::S_DS_OP;
                end
                else if (!phase_reg)
                begin
                    state_next = qets_pkg::S_DS_NEXT;
                end
                else
                begin
                    state_next = qets_pkg::S_FIN;
                end
            end
            qets_pkg::S_DS_OP:   state_next = qets_pkg::S_SP_RA;
            qets_pkg::S_DS_NEXT: state_next = qets_pkg::S_DS_RD;
            qets_pkg::S_WK_INIT:
            begin
                state_next = (cnt_reg == '0) ? qets_pkg::S_WK_END : qets_pkg::S_WK_RD;
            end
            qets_pkg::S_WK_RD:   state_next = qets_pkg::S_WK_CAP;
            qets_pkg::S_WK_CAP:
            begin
                state_next = (cnt_reg == qets_pkg::CNT_W'(1)) ? qets_pkg::S_WK_END
                                                              : qets_pkg::S_WK_RD;
            end
            qets_pkg::S_WK_END:  state_next = qets_pkg::S_FIN;
            qets_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = qets_pkg::S_IDLE;
                end
            end
            default:             state_next = qets_pkg::S_IDLE;
        endcase
    end

    // Link memory requests.
    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            qets_pkg::S_MK0:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = qets_pkg::with_code(a_reg, qets_pkg::TURN_0);
                mem_req.wdata = qets_pkg::with_code(a_reg, qets_pkg::TURN_0);
            end
            qets_pkg::S_MK1:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = qets_pkg::with_code(a_reg, qets_pkg::TURN_2);
                mem_req.wdata = qets_pkg::with_code(a_reg, qets_pkg::TURN_2);
            end
            qets_pkg::S_MK2:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = qets_pkg::with_code(a_reg, qets_pkg::TURN_1);
                mem_req.wdata = qets_pkg::with_code(a_reg, qets_pkg::TURN_3);
            end
            qets_pkg::S_MK3:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = qets_pkg::with_code(a_reg, qets_pkg::TURN_3);
                mem_req.wdata = qets_pkg::with_code(a_reg, qets_pkg::TURN_1);
            end
            qets_pkg::S_SP_RA, qets_pkg::S_DS_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = a_reg;
            end
            qets_pkg::S_SP_RB:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = b_reg;
            end
            qets_pkg::S_SP_RU, qets_pkg::S_SP_RV, qets_pkg::S_WK_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = turned;
            end
            qets_pkg::S_DS_CHK:
            begin
                mem_req.re   = !same;
                mem_req.addr = turned;
            end
            qets_pkg::S_SP_WA:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = a_reg;
                mem_req.wdata = tb_reg;
            end
            qets_pkg::S_SP_WB:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = b_reg;
                mem_req.wdata = ta_reg;
            end
            qets_pkg::S_SP_WU:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = u_reg;
                mem_req.wdata = tv_reg;
            end
            qets_pkg::S_SP_WV:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = v_reg;
                mem_req.wdata = tu_reg;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        rot_next       = rot_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        tu_next        = tu_reg;
        tv_next        = tv_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_arc_next   = out_arc_reg;
        unique case (state_reg)
            qets_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = qets_pkg::qets_mode_t'(cmd.mode);
                    phase_next = 1'b0;
                    a_next     = in_a;
                    b_next     = in_b;
                    rot_next   = cmd.rot_count;
                    neg_next   = cmd.step_count[qets_pkg::STEP_W-1];
                    cnt_next   = (step_mag > qets_pkg::MAG_W'(qets_pkg::STEP_CAP))
                               ? qets_pkg::CNT_W'(qets_pkg::STEP_CAP)
                               : qets_pkg::CNT_W'(step_mag);
                    res_next   = (qets_pkg::qets_mode_t'(cmd.mode) == qets_pkg::MODE_MAKE)
                               ? qets_pkg::with_code(in_a, qets_pkg::TURN_0) : in_a;
                end
            end
            qets_pkg::S_SP_RB: ta_next = rdata;
            qets_pkg::S_SP_RU:
            begin
                tb_next = rdata;
                u_next  = turned;
            end
            qets_pkg::S_SP_RV:
            begin
                tu_next = rdata;
                v_next  = turned;
            end
            qets_pkg::S_SP_WA: tv_next = rdata;
            qets_pkg::S_DS_OP: b_next  = turned;
            qets_pkg::S_DS_NEXT:
            begin
                a_next     = turned;
                phase_next = 1'b1;
            end
            qets_pkg::S_WK_INIT: a_next = turned;
            qets_pkg::S_WK_CAP:
            begin
                a_next   = turned;
                cnt_next = cnt_reg - qets_pkg::CNT_W'(1);
            end
            qets_pkg::S_WK_END: res_next = turned;
            qets_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_arc_next   = res_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qets_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        phase_reg   <= phase_next;
        neg_reg     <= neg_next;
        cnt_reg     <= cnt_next;
        rot_reg     <= rot_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        ta_reg      <= ta_next;
        tb_reg      <= tb_next;
        tu_reg      <= tu_next;
        tv_reg      <= tv_next;
        res_reg     <= res_next;
        out_arc_reg <= out_arc_next;
    end

endmodule

// ===== design/quad_edge_topology_store.sv =====
// ----------------------------------------------------------------------------
// quad_edge_topology_store: quad-edge store for planar subdivisions
// Keeps four arc links per edge record and performs one topology operation
// (make edge, splice, destroy edge, walk) per item.
// ----------------------------------------------------------------------------
// The host sends operation items on cmd and takes one resulting arc item per
// operation on rsp; both are valid/ready channels. The block takes one item
// at a time: cmd.ready is high only while the sequencer is idle.
// Every link access goes through the single port of the link memory, one
// read or one write per cycle, and the operations use that port as follows:
//   make edge  writes the four links of the new edge record,
//   splice     reads four links, then writes four links,
//   destroy    checks both ends of the edge in turn and splices out each
//              end that still has links,
//   walk       follows |n| links, n saturated to the step limit.
// The result register drives rsp directly, so the result can be taken in the
// cycle after it is loaded. A finished result waits in the
// output register, and the next item is accepted while it waits; if the
// receiver still stalls when the following result is done, the sequencer
// holds that result until the register frees up.
// Reset clears the sequencer and the output valid flag only. The link memory
// is not cleared: the host sets up each record with make edge before any
// other operation touches it, and records are allocated by the host.
// ----------------------------------------------------------------------------
module quad_edge_topology_store (
    input  logic      clk,
    input  logic      rst_n,
    qets_cmd_if.sink  cmd,
    qets_rsp_if.source rsp
);

    qets_pkg::qets_mem_req_t mem_req;
    qets_pkg::arc_t          mem_rdata;

    // The sequencer walks each operation through its link reads and writes
    // and owns the output register.
    qets_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    // Link memory: one entry per arc, addressed by edge index and tumble
    // code; each entry holds the onext arc of its address.
    qets_ram #(
        .WIDTH (qets_pkg::ARC_W),
        .DEPTH (qets_pkg::SLOT_COUNT)
    ) u_links (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule

// ===== design/qets_checker.sv =====
// ----------------------------------------------------------------------------
// qets_checker: port-level checks of the quad-edge topology store
// Watches the operation and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module qets_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic [qets_pkg::MODE_W-1:0]    cmd_mode,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [qets_pkg::IN_EDGE_W-1:0] rsp_edge,
    input logic [qets_pkg::CODE_W-1:0]    rsp_code
);

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge) && $stable(rsp_code))
        else $error("result changed while stalled");

    // One operation at a time: the block is busy right after an accept.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second item accepted while busy");

    // A result appears only as the sequencer returns to idle.
    a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> cmd_ready)
        else $error("result appeared while an operation was still running");

    // A make edge accepted with a free output shows a base arc on rsp.
    a_make: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !rsp_valid && cmd_mode == qets_pkg::MODE_MAKE
        |-> ##6 rsp_valid && rsp_code == qets_pkg::TURN_0)
        else $error("make edge result missing or not a base arc");

endmodule

bind quad_edge_topology_store qets_checker u_qets_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_mode  (cmd.mode),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_edge  (rsp.result_edge),
    .rsp_code  (rsp.result_code)
);
